// ===== design/tpcw_pkg.sv =====
// Shared types, constants and helpers for the track pixel charge walk block.
`default_nettype none
package tpcw_pkg;
    localparam int COORD_W   = 28;
    localparam int LEN_W     = 20;
    localparam int IDX_W     = 20;
    localparam int OIDX_W    = 16;
    localparam int ENERGY_W  = 32;
    localparam int Q_W       = 31;
    localparam int RCP_W     = 23;
    localparam int RCP_SH    = 47;
    localparam int CHG_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int SQ_W      = 14;

    localparam int MAX_PIXELS_DEF = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_THRESHOLD = 2'd2;

    localparam logic [LEN_W-1:0]  PIXEL_RESET   = 20'd100000;
    localparam logic [LEN_W-1:0]  MIN_PIXEL     = 20'd1000;
    localparam logic [CHG_W-1:0]  THR_RESET     = 32'd0;
    // 100 * ceil(2^47 / 361): energy * Q_RECIP >> 47 == energy * 100 / 361
    localparam logic [2*RCP_W-1:0] Q_RECIP      = 46'd38985453838100;
    localparam logic [COORD_W-1:0] SHORT_LEN    = 28'd10000;
    localparam logic [2*SQ_W:0]   SHORT_LEN_SQ  = 29'd100000000;

    typedef struct packed {
        logic [COORD_W-1:0]  entry_x;
        logic [COORD_W-1:0]  entry_y;
        logic [COORD_W-1:0]  exit_x;
        logic [COORD_W-1:0]  exit_y;
        logic [ENERGY_W-1:0] deposited_energy;
    } t_in;

    typedef struct packed {
        logic [OIDX_W-1:0] pixel_column;
        logic [OIDX_W-1:0] pixel_row;
        logic [CHG_W-1:0]  pixel_charge;
        logic              pixel_hit;
        logic              last_pixel;
        logic              walk_truncated;
    } t_res;

    typedef struct packed {
        logic signed [IDX_W-1:0] col;
        logic signed [IDX_W-1:0] row;
        logic [COORD_W-1:0]      nx;
        logic [COORD_W-1:0]      ny;
        logic [COORD_W-1:0]      ax;
        logic [COORD_W-1:0]      ay;
        logic                    right;
        logic                    up;
        logic [Q_W-1:0]          q;
        logic                    short_seg;
    } t_job;

    function automatic logic [OIDX_W-1:0] clamp_idx(input logic signed [IDX_W-1:0] v);
        logic [OIDX_W-1:0] r;
        if (v < 0) r = '0;
        else if (v > $signed({{(IDX_W-OIDX_W){1'b0}}, {OIDX_W{1'b1}}})) r = '1;
        else r = v[OIDX_W-1:0];
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== design/tpcw_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module tpcw_div #(
    parameter int NW = 28,
    parameter int DW = 20
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_busy,
    output logic [NW-1:0]      o_quo,
    output logic [DW-1:0]      o_rem
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DW:0]   n_trial;
    logic [DW:0]   n_diff;
    logic          n_ge;

    always_comb begin
        n_trial = {r_rem, r_quo[NW-1]};
        n_diff  = n_trial - {1'b0, r_den};
        n_ge    = n_trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
            r_quo  <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[DW-1:0] : n_trial[DW-1:0];
            r_quo <= {r_quo[NW-2:0], n_ge};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_busy <= 1'b0;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

// ===== design/tpcw_front.sv =====
// Front end: takes a track, finds entry pixel, borders and total charge.
`default_nettype none
module tpcw_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire tpcw_pkg::t_in         i_in_data,
    input  wire logic [tpcw_pkg::LEN_W-1:0] i_len,
    input  wire logic [tpcw_pkg::LEN_W-1:0] i_wid,
    output logic                       o_push,
    input  wire logic                  i_full,
    output tpcw_pkg::t_job             o_job
);
    import tpcw_pkg::*;

    localparam int PP_W = ENERGY_W + RCP_W;
    localparam int QS_W = ENERGY_W + 2 * RCP_W;

    typedef enum logic {F_IDLE, F_DIV} t_fstate;

    t_fstate            r_state;
    logic [COORD_W-1:0] r_ax, r_ay;
    logic               r_right, r_up;
    logic [PP_W-1:0]    r_plo, r_phi;
    logic               n_accept;
    logic [COORD_W-1:0] n_dx, n_dy;
    logic               n_busy;
    logic               col_busy, row_busy;
    logic [COORD_W-1:0] col_quo, row_quo;
    logic [LEN_W-1:0]   col_rem, row_rem;
    logic [QS_W-1:0]    n_qsum;
    logic [2*SQ_W-1:0]  n_sqx, n_sqy;
    logic [2*SQ_W:0]    n_sq;
    logic               n_short;

    assign n_accept   = i_in_valid && (r_state == F_IDLE);
    assign o_in_stall = (r_state != F_IDLE);
    assign n_dx = (i_in_data.exit_x > i_in_data.entry_x) ? i_in_data.exit_x - i_in_data.entry_x
                                                         : i_in_data.entry_x - i_in_data.exit_x;
    assign n_dy = (i_in_data.exit_y > i_in_data.entry_y) ? i_in_data.exit_y - i_in_data.entry_y
                                                         : i_in_data.entry_y - i_in_data.exit_y;

    tpcw_div #(.NW(COORD_W), .DW(LEN_W)) u_col_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(n_accept),
        .i_num(i_in_data.entry_x), .i_den(i_len),
        .o_busy(col_busy), .o_quo(col_quo), .o_rem(col_rem)
    );
    tpcw_div #(.NW(COORD_W), .DW(LEN_W)) u_row_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(n_accept),
        .i_num(i_in_data.entry_y), .i_den(i_wid),
        .o_busy(row_busy), .o_quo(row_quo), .o_rem(row_rem)
    );

    assign n_busy = col_busy || row_busy;

    // total charge: partial products registered at accept, summed here
    assign n_qsum = {r_phi, {RCP_W{1'b0}}} + QS_W'(r_plo);

    always_comb begin
        n_sqx   = r_ax[SQ_W-1:0] * r_ax[SQ_W-1:0];
        n_sqy   = r_ay[SQ_W-1:0] * r_ay[SQ_W-1:0];
        n_sq    = {1'b0, n_sqx} + {1'b0, n_sqy};
        n_short = (r_ax < SHORT_LEN) && (r_ay < SHORT_LEN) && (n_sq < SHORT_LEN_SQ);
    end

    always_comb begin
        o_job.col   = {1'b0, col_quo[IDX_W-2:0]};
        o_job.row   = {1'b0, row_quo[IDX_W-2:0]};
        o_job.nx    = COORD_W'(r_right ? i_len - col_rem : col_rem);
        o_job.ny    = COORD_W'(r_up ? i_wid - row_rem : row_rem);
        o_job.ax    = r_ax;
        o_job.ay    = r_ay;
        o_job.right = r_right;
        o_job.up    = r_up;
        o_job.q     = n_qsum[QS_W-1:RCP_SH];
        o_job.short_seg = n_short;
    end

    assign o_push = (r_state == F_DIV) && !n_busy && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (n_accept) begin
                        r_state <= F_DIV;
                        r_ax    <= n_dx;
                        r_ay    <= n_dy;
                        r_right <= i_in_data.exit_x > i_in_data.entry_x;
                        r_up    <= i_in_data.exit_y > i_in_data.entry_y;
                        r_plo   <= PP_W'(i_in_data.deposited_energy)
                                   * PP_W'(Q_RECIP[RCP_W-1:0]);
                        r_phi   <= PP_W'(i_in_data.deposited_energy)
                                   * PP_W'(Q_RECIP[2*RCP_W-1:RCP_W]);
                    end
                end
                F_DIV: begin
                    if (o_push) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== design/tpcw_fifo.sv =====
// Two-entry job queue between front and back.
`default_nettype none
module tpcw_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tpcw_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output tpcw_pkg::t_job      o_job
);
    import tpcw_pkg::*;

    t_job       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

// ===== design/tpcw_back.sv =====
// Back end: walks pixel borders, splits charge, applies threshold.
`default_nettype none
module tpcw_back #(
    parameter int MAX_PIXELS = tpcw_pkg::MAX_PIXELS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_job_empty,
    output logic                             o_job_pop,
    input  wire tpcw_pkg::t_job              i_job,
    input  wire logic [tpcw_pkg::LEN_W-1:0]  i_len,
    input  wire logic [tpcw_pkg::LEN_W-1:0]  i_wid,
    input  wire logic [tpcw_pkg::CHG_W-1:0]  i_thr,
    output logic                             o_out_valid,
    output tpcw_pkg::t_res                   o_out_data,
    input  wire logic                        i_out_stall
);
    import tpcw_pkg::*;

    localparam int KW = (MAX_PIXELS > 2) ? $clog2(MAX_PIXELS) : 1;
    localparam int PW = Q_W + COORD_W;
    localparam logic signed [IDX_W-1:0] IDX_ONE = IDX_W'(1);

    typedef enum logic [2:0] {B_IDLE, B_SHORT, B_CMP, B_SEL, B_MUL, B_DIVW, B_DEC} t_bstate;

    t_bstate                 r_state;
    logic signed [IDX_W-1:0] r_col, r_row;
    logic [COORD_W-1:0]      r_nx, r_ny, r_ax, r_ay, r_num, r_den;
    logic                    r_right, r_up, r_xfirst, r_stop, r_last;
    logic [Q_W-1:0]          r_q;
    logic [CHG_W-1:0]        r_clast, r_cout;
    logic [KW-1:0]           r_k;
    logic [2*COORD_W-1:0]    r_p1, r_p2;
    logic                    r_ovalid;
    t_res                    r_out;

    logic                    div_busy;
    logic [PW-1:0]           div_quo;
    logic [COORD_W-1:0]      div_rem;
    logic                    n_free, n_xfirst, n_hit, n_need, n_emit;
    logic [COORD_W-1:0]      n_num, n_den;
    logic [CHG_W-1:0]        n_charge;

    assign n_free = !r_ovalid || !i_out_stall;
    assign o_job_pop = (r_state == B_IDLE) && !i_job_empty;

    tpcw_div #(.NW(PW), .DW(COORD_W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_state == B_MUL),
        .i_num(PW'(r_q) * PW'(r_num)), .i_den(r_den),
        .o_busy(div_busy), .o_quo(div_quo), .o_rem(div_rem)
    );

    always_comb begin
        if (r_ax == '0) n_xfirst = 1'b0;
        else if (r_ay == '0) n_xfirst = 1'b1;
        else n_xfirst = r_p1 < r_p2;
        n_num    = n_xfirst ? r_nx : r_ny;
        n_den    = n_xfirst ? r_ax : r_ay;
        n_charge = (r_cout > r_clast) ? r_cout - r_clast : '0;
        n_hit    = n_charge > i_thr;
        n_need   = n_hit || r_last;
        n_emit   = n_free && ((r_state == B_SHORT) || ((r_state == B_DEC) && n_need));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
            r_k      <= '0;
        end else begin
            r_ovalid <= n_emit || (r_ovalid && i_out_stall);
            case (r_state)
                B_IDLE: begin
                    if (!i_job_empty) begin
                        r_col   <= i_job.col;
                        r_row   <= i_job.row;
                        r_nx    <= i_job.nx;
                        r_ny    <= i_job.ny;
                        r_ax    <= i_job.ax;
                        r_ay    <= i_job.ay;
                        r_right <= i_job.right;
                        r_up    <= i_job.up;
                        r_q     <= i_job.q;
                        r_clast <= '0;
                        r_k     <= '0;
                        r_state <= i_job.short_seg ? B_SHORT : B_CMP;
                    end
                end
                B_SHORT: begin
                    if (n_free) begin
                        r_out    <= '{pixel_column: clamp_idx(r_col),
                                      pixel_row: clamp_idx(r_row),
                                      pixel_charge: CHG_W'(r_q), pixel_hit: 1'b1,
                                      last_pixel: 1'b1, walk_truncated: 1'b0};
                        r_state  <= B_IDLE;
                    end
                end
                B_CMP: begin
                    r_p1    <= r_nx * r_ay;
                    r_p2    <= r_ny * r_ax;
                    r_state <= B_SEL;
                end
                B_SEL: begin
                    r_xfirst <= n_xfirst;
                    r_num    <= n_num;
                    r_den    <= n_den;
                    r_stop   <= n_num > n_den;
                    r_last   <= (n_num > n_den) || (r_k == KW'(MAX_PIXELS - 1));
                    if (n_num > n_den) begin
                        r_cout  <= CHG_W'(r_q);
                        r_state <= B_DEC;
                    end else begin
                        r_state <= B_MUL;
                    end
                end
                B_MUL: r_state <= B_DIVW;
                B_DIVW: begin
                    if (!div_busy) begin
                        r_cout  <= div_quo[CHG_W-1:0];
                        r_state <= B_DEC;
                    end
                end
                B_DEC: begin
                    if (!n_need || n_free) begin
                        if (n_need) begin
                            r_out    <= '{pixel_column: clamp_idx(r_col),
                                          pixel_row: clamp_idx(r_row),
                                          pixel_charge: n_hit ? n_charge : '0,
                                          pixel_hit: n_hit, last_pixel: r_last,
                                          walk_truncated: r_last && !r_stop};
                        end
                        if (n_hit) r_clast <= r_cout;
                        if (r_last) begin
                            r_state <= B_IDLE;
                        end else begin
                            if (r_xfirst) begin
                                r_col <= r_right ? r_col + IDX_ONE : r_col - IDX_ONE;
                                r_nx  <= r_nx + COORD_W'(i_len);
                            end else begin
                                r_row <= r_up ? r_row + IDX_ONE : r_row - IDX_ONE;
                                r_ny  <= r_ny + COORD_W'(i_wid);
                            end
                            r_k     <= r_k + 1'b1;
                            r_state <= B_CMP;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_div_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_state == B_DIVW)) else $error("divider busy outside wait");
    a_charge_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DEC) |-> (r_clast <= CHG_W'(r_q))) else $error("charge overrun");
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_SEL) |-> (r_k <= KW'(MAX_PIXELS - 1))) else $error("walk too long");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_state == B_SHORT || r_state == B_CMP)) else $error("bad job load");
`endif
endmodule
`default_nettype wire

// ===== design/track_pixel_charge_walk_top.sv =====
// Top level: configuration registers, front end, job queue and back end.
//   channel   dir  handshake              payload
//   in        in   i_in_valid/o_in_stall  t_in   (one track segment)
//   out       out  o_out_valid/i_out_stall t_res (one pixel request)
//   cfg       in   i_cfg_we               i_cfg_idx, i_cfg_data
// Front end takes a track, stalls until its 28-step pixel index dividers finish.
// Back end visits each pixel with compare, select, start, the 59-step charge split
// divider and decide; on the pixel where the walk stops it skips the divider. It
// loads each track in idle; a short segment goes straight to its single request.
// Reset is synchronous, active low; registers come up at 100000/100000/0.
// Output stall only holds the back end; the front keeps going until the queue fills.
`default_nettype none
module track_pixel_charge_walk_top #(
    parameter int MAX_PIXELS = tpcw_pkg::MAX_PIXELS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire tpcw_pkg::t_in                   i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output tpcw_pkg::t_res                       o_out_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [tpcw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tpcw_pkg::CFG_W-1:0]      i_cfg_data
);
    import tpcw_pkg::*;

    logic [LEN_W-1:0] r_len, r_wid;
    logic [CHG_W-1:0] r_thr;
    logic [LEN_W-1:0] n_len, n_wid;
    logic             push, full, pop, empty;
    t_job             front_job, back_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= PIXEL_RESET;
            r_wid <= PIXEL_RESET;
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PIXEL_LENGTH:     r_len <= i_cfg_data[LEN_W-1:0];
                CFG_PIXEL_WIDTH:      r_wid <= i_cfg_data[LEN_W-1:0];
                CFG_CHARGE_THRESHOLD: r_thr <= i_cfg_data[CHG_W-1:0];
                default: ;
            endcase
        end
    end

    assign n_len = (r_len < MIN_PIXEL) ? MIN_PIXEL : r_len;
    assign n_wid = (r_wid < MIN_PIXEL) ? MIN_PIXEL : r_wid;

    tpcw_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .i_len(n_len), .i_wid(n_wid),
        .o_push(push), .i_full(full), .o_job(front_job)
    );

    tpcw_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_job(front_job), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_job(back_job)
    );

    tpcw_back #(.MAX_PIXELS(MAX_PIXELS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_empty(empty), .o_job_pop(pop), .i_job(back_job),
        .i_len(n_len), .i_wid(n_wid), .i_thr(r_thr),
        .o_out_valid(o_out_valid), .o_out_data(o_out_data), .i_out_stall(i_out_stall)
    );
endmodule
`default_nettype wire

// ===== tb/tb_track_pixel_charge_walk_top.sv =====
// Self-checking testbench for the track pixel charge walk block: predicts every pixel request.
`timescale 1ns / 100ps
module tb_track_pixel_charge_walk_top;
    import tpcw_pkg::*;

    localparam int  MAXPIX = 64;
    localparam int  HOLD_CYCLES = 3000;
    localparam logic [COORD_W-1:0] CMAX = {COORD_W{1'b1}};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_res                 o_out_data;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    t_in  pend_tracks[$];
    t_res exp_pixels[$];
    int   err_cnt = 0;
    bit   quiet = 1'b0;
    bit   hold_req = 1'b0;
    int   in_gap = 0;
    int   out_gap = 0;
    int   hold_cnt = 0;

    longint pix_len = 100000;
    longint pix_wid = 100000;
    longint thr = 0;

    track_pixel_charge_walk_top #(.MAX_PIXELS(MAXPIX)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic void push_pixel(longint col, longint row, longint chg,
                                       bit hit, bit lst, bit trn);
        t_res r;
        r.pixel_column = (col < 0) ? 16'd0 : (col > 65535) ? 16'hFFFF : col[15:0];
        r.pixel_row    = (row < 0) ? 16'd0 : (row > 65535) ? 16'hFFFF : row[15:0];
        r.pixel_charge = (chg > 64'hFFFFFFFF) ? 32'hFFFFFFFF : chg[31:0];
        r.pixel_hit      = hit;
        r.last_pixel     = lst;
        r.walk_truncated = trn;
        exp_pixels.insert(exp_pixels.size(), r);
    endfunction

    // Walk one segment across the pixel grid and queue the pixels it yields.
    function automatic void walk_track(t_in t);
        longint ex, ey, dx, dy, ax, ay, len, wid, q, col, row, c_last;
        longint bx, by, nx, ny, num, den, c_out, chg;
        bit right, up, xfirst, stop, lst, trn;
        ex = t.entry_x; ey = t.entry_y;
        dx = longint'(t.exit_x) - ex;
        dy = longint'(t.exit_y) - ey;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        right = dx > 0; up = dy > 0;
        len = pix_len < 1000 ? 1000 : pix_len;
        wid = pix_wid < 1000 ? 1000 : pix_wid;
        q = (longint'(t.deposited_energy) * 100) / 361;
        col = ex / len; row = ey / wid;
        c_last = 0;
        if (ax * ax + ay * ay < 100000000) begin
            push_pixel(col, row, q, 1, 1, 0);
            return;
        end
        for (int k = 0; k < MAXPIX; k++) begin
            bx = right ? len * (col + 1) : len * col;
            by = up ? wid * (row + 1) : wid * row;
            nx = right ? bx - ex : ex - bx;
            ny = up ? by - ey : ey - by;
            if (nx < 0) nx = 0;
            if (ny < 0) ny = 0;
            if (ax == 0) xfirst = 0;
            else if (ay == 0) xfirst = 1;
            else xfirst = nx * ay < ny * ax;
            num = xfirst ? nx : ny;
            den = xfirst ? ax : ay;
            stop = num > den;
            c_out = stop ? q : (q * num) / den;
            chg = c_out > c_last ? c_out - c_last : 0;
            lst = stop || (k == MAXPIX - 1);
            trn = lst && !stop;
            if (chg > thr) begin
                push_pixel(col, row, chg, 1, lst, trn);
                c_last = c_out;
            end else if (lst) begin
                push_pixel(col, row, 0, 0, 1, trn);
            end
            if (lst) break;
            if (xfirst) col += right ? 1 : -1;
            else row += up ? 1 : -1;
        end
    endfunction

    // Sender: offers pending tracks, predicts each accepted request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) walk_track(i_in_data);
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    in_gap = $urandom_range(1, 19);
                    i_in_valid <= 1'b0;
                end else if (pend_tracks.size() > 0) begin
                    i_in_data  <= pend_tracks.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall: random bursts plus one long hold-off.
    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            out_gap = $urandom_range(1, 19);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_pixels.size() == 0) begin
                err_cnt++;
                $display("%0t unexpected request: expected none, actual %p", $time, o_out_data);
            end else begin
                e = exp_pixels.pop_front();
                if (o_out_data !== e) begin
                    err_cnt++;
                    $display("%0t mismatch: expected %p, actual %p", $time, e, o_out_data);
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_PIXEL_LENGTH:     pix_len = val[LEN_W-1:0];
            CFG_PIXEL_WIDTH:      pix_wid = val[LEN_W-1:0];
            CFG_CHARGE_THRESHOLD: thr = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pend_tracks.size() > 0 || i_in_valid || exp_pixels.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic void add_track(longint ex, longint ey, longint ox, longint oy,
                                      logic [31:0] en);
        t_in t;
        t.entry_x = ex[COORD_W-1:0];
        t.entry_y = ey[COORD_W-1:0];
        t.exit_x  = ox[COORD_W-1:0];
        t.exit_y  = oy[COORD_W-1:0];
        t.deposited_energy = en;
        pend_tracks.insert(pend_tracks.size(), t);
    endfunction

    function automatic longint pick_delta(longint span);
        longint d;
        d = $urandom_range(0, 32'(span));
        return $urandom_range(0, 1) ? d : -d;
    endfunction

    function automatic void add_random(int n);
        longint ex, ey, ox, oy, dx, dy, len, wid;
        int mode;
        len = pix_len < 1000 ? 1000 : pix_len;
        wid = pix_wid < 1000 ? 1000 : pix_wid;
        for (int i = 0; i < n; i++) begin
            ex = $urandom & CMAX;
            ey = $urandom & CMAX;
            mode = $urandom_range(0, 19);
            dx = pick_delta(3 * len);
            dy = pick_delta(3 * wid);
            if (mode < 2) begin
                dx = pick_delta(7000);
                dy = pick_delta(7000);
            end else if (mode == 2) begin
                dy = 0;
            end else if (mode == 3) begin
                dx = 0;
            end
            ox = ex + dx; oy = ey + dy;
            if (ox < 0 || ox > CMAX) ox = ex - dx;
            if (oy < 0 || oy > CMAX) oy = ey - dy;
            if (mode == 4) begin
                ox = $urandom & CMAX;
                oy = $urandom & CMAX;
            end
            add_track(ex, ey, ox, oy, $urandom_range(0, 3) == 0 ? $urandom_range(0, 2000)
                                                                : $urandom);
        end
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_track(CMAX, CMAX, CMAX, CMAX, 32'hFFFFFFFF);
        add_track(50000, 150000, 450000, 150000, 1000000);
        add_track(250000, 450000, 250000, 20000, 0);
        add_track(50000, 50000, 250000, 250000, 5000000);
        add_track(370000, 290000, 30000, 110000, 123456789);
        add_track(50000, 50000, 200000, 50000, 7777777);
        add_track(50000, 20000, 0, 20000, 360000);
        add_track(0, 0, 9999, 0, 1000);
        add_track(0, 0, 6000, 8000, 999);
        add_track(10, 0, 30000, 900000, 32'hFFFFFFFF);
        add_track(0, 0, CMAX, CMAX, 32'hFFFFFFFF);
        add_track(CMAX, 0, 0, CMAX, 32'h80000000);
        add_random(90);
        drain();

        write_reg(CFG_PIXEL_LENGTH, 1000);
        write_reg(CFG_PIXEL_WIDTH, 1000);
        add_track(CMAX, CMAX, CMAX - 15, CMAX - 4095, 32'h12345678);
        add_track(CMAX, 5000, CMAX - 20000, 5000, 32'hFFFFFFFF);
        hold_req = 1'b1;
        add_random(100);
        drain();

        write_reg(CFG_PIXEL_LENGTH, 32'hFFFFF);
        write_reg(CFG_PIXEL_WIDTH, 3);
        write_reg(CFG_CHARGE_THRESHOLD, 2000000);
        add_track(100, 100, 100, 40000, 100000);
        add_random(80);
        drain();

        write_reg(CFG_PIXEL_LENGTH, 1000);
        write_reg(CFG_PIXEL_WIDTH, 500000);
        write_reg(CFG_CHARGE_THRESHOLD, 32'hFFFFFFFF);
        add_track(1000, 1000, 90000, 2000000, 32'hFFFFFFFF);
        add_random(50);
        drain();

        write_reg(CFG_PIXEL_LENGTH, 100000);
        write_reg(CFG_PIXEL_WIDTH, 100000);
        write_reg(CFG_CHARGE_THRESHOLD, 1000);
        quiet = 1'b1;
        add_random(75);
        drain();

        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== filelist.f =====
design/tpcw_pkg.sv
design/tpcw_div.sv
design/tpcw_front.sv
design/tpcw_fifo.sv
design/tpcw_back.sv
design/track_pixel_charge_walk_top.sv
tb/tb_track_pixel_charge_walk_top.sv
